FILE: rtl/tea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared types, constants and the round mixing function of the TEA pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  // Key schedule constant added once per round.
  localparam logic [31:0] DELTA = 32'h9e37_79b9;

  // Operation selected by the func field.
  typedef enum logic {
    FUNC_ENCRYPT = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } cfg_reg_t;

  // The 128-bit key as four words.
  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    func_t       func;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } stage_t;

  // Mixing function of one half-round.
  function automatic logic [31:0] tea_mix(input logic [31:0] x,
                                          input logic [31:0] sum,
                                          input logic [31:0] ka,
                                          input logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

FILE: rtl/tea_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA input channel
// Valid/ready channel carrying the operation and the two block words.
// ----------------------------------------------------------------------------
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] block_low_in;
  logic [31:0] block_high_in;

  modport source (output valid, func, block_low_in, block_high_in, input ready);
  modport sink   (input valid, func, block_low_in, block_high_in, output ready);
endinterface

FILE: rtl/tea_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA result channel
// Valid/ready channel carrying the two transformed block words.
// ----------------------------------------------------------------------------
interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_low_out;
  logic [31:0] block_high_out;

  modport source (output valid, block_low_out, block_high_out, input ready);
  modport sink   (input valid, block_low_out, block_high_out, output ready);
endinterface

FILE: rtl/tea_half_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA half-round cell
// One registered half-round. Encryption and decryption share the cell: the
// word that is updated and the key pair used follow from the operation and
// from which half of the round the cell holds.
// ----------------------------------------------------------------------------
module tea_half_cell #(
  parameter bit SECOND_HALF = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  tea_pkg::key_t   key,
  input  logic            prev_valid,
  input  tea_pkg::stage_t prev_stage,
  output logic            valid_r,
  output tea_pkg::stage_t stage_r
);
  import tea_pkg::*;

  logic        is_enc;
  logic        upd_v0;
  logic [31:0] src_word;
  logic [31:0] tgt_word;
  logic [31:0] mix_val;
  logic [31:0] new_word;
  logic [31:0] sum_nxt;
  stage_t      stage_nxt;

  // Select the word to update, its source word and the key pair.
  assign is_enc   = (prev_stage.func == FUNC_ENCRYPT);
  assign upd_v0   = is_enc ^ SECOND_HALF;
  assign src_word = upd_v0 ? prev_stage.v1 : prev_stage.v0;
  assign tgt_word = upd_v0 ? prev_stage.v0 : prev_stage.v1;
  assign mix_val  = upd_v0 ? tea_mix(src_word, prev_stage.sum, key.k0, key.k1)
                           : tea_mix(src_word, prev_stage.sum, key.k2, key.k3);
  assign new_word = is_enc ? (tgt_word + mix_val) : (tgt_word - mix_val);

  // The running sum steps once per round, at the end of the second half.
  always_comb begin
    if (SECOND_HALF) begin
      sum_nxt = is_enc ? (prev_stage.sum + DELTA) : (prev_stage.sum - DELTA);
    end else begin
      sum_nxt = prev_stage.sum;
    end
  end

  always_comb begin
    stage_nxt      = prev_stage;
    stage_nxt.sum  = sum_nxt;
    if (upd_v0) begin
      stage_nxt.v0 = new_word;
    end else begin
      stage_nxt.v1 = new_word;
    end
  end

  // Valid bit of the cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  // Payload register of the cell.
  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

FILE: rtl/tea_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA output buffer
// Output register with a one-word skid stage. The cell row moves whenever the
// skid stage is empty, so a waiting result does not hold up new input.
// ----------------------------------------------------------------------------
module tea_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            last_valid,
  input  tea_pkg::stage_t last_stage,
  output logic            en,
  tea_out_if.source       out_ch
);
  import tea_pkg::*;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_low_r;
  logic [31:0] out_low_nxt;
  logic [31:0] out_high_r;
  logic [31:0] out_high_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  logic [31:0] skid_low_r;
  logic [31:0] skid_low_nxt;
  logic [31:0] skid_high_r;
  logic [31:0] skid_high_nxt;
  logic        take;
  logic        pop;

  // The row advances only while the skid stage is free.
  assign en   = !skid_valid_r;
  assign take = last_valid && en;
  assign pop  = out_valid_r && out_ch.ready;

  // Next state of the output register and the skid stage.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;
    skid_valid_nxt = skid_valid_r;
    skid_low_nxt   = skid_low_r;
    skid_high_nxt  = skid_high_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_low_nxt    = skid_low_r;
        out_high_nxt   = skid_high_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = take;
      if (take) begin
        out_low_nxt  = last_stage.v0;
        out_high_nxt = last_stage.v1;
      end
    end else if (take) begin
      skid_valid_nxt = 1'b1;
      skid_low_nxt   = last_stage.v0;
      skid_high_nxt  = last_stage.v1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_low_r   <= out_low_nxt;
    out_high_r  <= out_high_nxt;
    skid_low_r  <= skid_low_nxt;
    skid_high_r <= skid_high_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.block_low_out  = out_low_r;
  assign out_ch.block_high_out = out_high_r;

endmodule

FILE: rtl/tea_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA block cipher
// Pipelined Tiny Encryption Algorithm on 64-bit blocks with a 128-bit key.
// ----------------------------------------------------------------------------
// The block takes one word per clock and gives one result per clock while
// the result side keeps up. Each word passes through a row of 2*ROUNDS
// half-round cells, one register each, and then the output register.
// Encrypt and decrypt words may be mixed freely. in_ch.ready is low only
// while the skid stage behind the cell row holds a word, that is after the
// result side has stalled for two results. The key registers are written
// through the cfg_ port and must only change while no word is in flight.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tea_in_if.sink                           in_ch,
  tea_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_wdata
);
  import tea_pkg::*;

  localparam int unsigned CELLS        = 2 * ROUNDS;
  localparam logic [63:0] SUM_PROD     = 64'(DELTA) * 64'(ROUNDS);
  localparam logic [31:0] SUM_DEC_INIT = SUM_PROD[31:0];

  key_t        key_r;
  logic        en;
  logic        cell_valid [0:CELLS];
  stage_t      cell_stage [0:CELLS];

  // Key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_WORD0: key_r.k0 <= cfg_wdata;
        REG_KEY_WORD1: key_r.k1 <= cfg_wdata;
        REG_KEY_WORD2: key_r.k2 <= cfg_wdata;
        REG_KEY_WORD3: key_r.k3 <= cfg_wdata;
        default:       key_r    <= key_r;
      endcase
    end
  end

  // Entry of the row: the running sum starts one step ahead for encryption.
  assign in_ch.ready   = en;
  assign cell_valid[0] = in_ch.valid;
  always_comb begin
    cell_stage[0].func = func_t'(in_ch.func);
    cell_stage[0].v0   = in_ch.block_low_in;
    cell_stage[0].v1   = in_ch.block_high_in;
    cell_stage[0].sum  = (in_ch.func == FUNC_DECRYPT) ? SUM_DEC_INIT : DELTA;
  end

  // Row of half-round cells, alternating first and second halves.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tea_half_cell #(
      .SECOND_HALF ((i % 2) == 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .key        (key_r),
      .prev_valid (cell_valid[i]),
      .prev_stage (cell_stage[i]),
      .valid_r    (cell_valid[i+1]),
      .stage_r    (cell_stage[i+1])
    );
  end

  // Output register and skid stage.
  tea_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_valid (cell_valid[CELLS]),
    .last_stage (cell_stage[CELLS]),
    .en         (en),
    .out_ch     (out_ch)
  );

endmodule

FILE: tb/tea_block_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// Drives encrypt and decrypt words through the pipelined cipher under several
// keys, with random idling on both channels and one long result-side stall.
// A behavioural copy of the cipher predicts the results, the directed table
// gives the known ones; each result word is checked in order against them.
// ----------------------------------------------------------------------------
module tea_block_cipher_tb;
  import tea_pkg::*;

  localparam int unsigned ROUND_COUNT      = 32;
  localparam int unsigned RESULT_LATENCY   = 2 * ROUND_COUNT + 1;
  localparam int unsigned PHASE_COUNT      = 6;
  localparam int unsigned WORDS_PER_PHASE  = 215;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTED      = 100;
  localparam int unsigned DIRECTED_COUNT   = 12;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } block_t;

  // One row of the directed table; the result is only used when known is set.
  typedef struct packed {
    func_t       op;
    logic [31:0] v0;
    logic [31:0] v1;
    bit          known;
    block_t      result;
  } vector_t;

  // Extremes of both words in both directions, plus the all-zero test vector
  // and its inverse under the all-zero reset key.
  vector_t directed_vectors [DIRECTED_COUNT] = '{
    '{FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, 64'h41ea3a0a_94baa940},
    '{FUNC_DECRYPT, 32'h41ea_3a0a, 32'h94ba_a940, 1'b1, 64'h00000000_00000000},
    '{FUNC_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 64'h0},
    '{FUNC_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 64'h0},
    '{FUNC_ENCRYPT, 32'h0000_0000, 32'hffff_ffff, 1'b0, 64'h0},
    '{FUNC_DECRYPT, 32'hffff_ffff, 32'h0000_0000, 1'b0, 64'h0},
    '{FUNC_ENCRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, 64'h0},
    '{FUNC_DECRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, 64'h0},
    '{FUNC_ENCRYPT, 32'h7fff_ffff, 32'hffff_fffe, 1'b0, 64'h0},
    '{FUNC_DECRYPT, 32'h1234_5678, 32'h9abc_def0, 1'b0, 64'h0},
    '{FUNC_ENCRYPT, 32'h9abc_def0, 32'h1234_5678, 1'b0, 64'h0},
    '{FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, 64'h41ea3a0a_94baa940}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_wdata;

  tea_in_if  in_ch ();
  tea_out_if out_ch ();

  tea_block_cipher #(
    .ROUNDS(ROUND_COUNT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  key_t        active_key;
  block_t      expected_blocks [$];
  block_t      last_result;
  func_t       last_op;
  int unsigned mismatch_count;
  bit          idle_on;
  int unsigned hold_off_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net in case a handshake never completes.
  initial begin
    #(5_000_000);
    $display("tea_block_cipher: mismatch");
    $finish;
  end

  // Mixing step of one half-round.
  function automatic logic [31:0] half_round_mix(input logic [31:0] x,
                                                 input logic [31:0] sum,
                                                 input logic [31:0] ka,
                                                 input logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  // Full 32-round transform of one block under the given key.
  function automatic block_t tea_transform(input func_t op, input logic [31:0] v0_in,
                                           input logic [31:0] v1_in, input key_t key);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    block_t      res;
    v0 = v0_in;
    v1 = v1_in;
    if (op == FUNC_ENCRYPT) begin
      sum = 32'h0;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        sum = sum + DELTA;
        v0  = v0 + half_round_mix(v1, sum, key.k0, key.k1);
        v1  = v1 + half_round_mix(v0, sum, key.k2, key.k3);
      end
    end else begin
      sum = DELTA * ROUND_COUNT;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        v1  = v1 - half_round_mix(v0, sum, key.k2, key.k3);
        v0  = v0 - half_round_mix(v1, sum, key.k0, key.k1);
        sum = sum - DELTA;
      end
    end
    res.lo = v0;
    res.hi = v1;
    return res;
  endfunction

  // Random word biased towards the extremes and single-bit patterns.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Compare one result word with the oldest expected block.
  task automatic check_block(input block_t got);
    block_t want;
    if (expected_blocks.size() == 0) begin
      report_mismatch("result word with nothing expected", got, 64'h0);
    end else begin
      want = expected_blocks.pop_front();
      if (got.lo !== want.lo) begin
        report_mismatch("block_low_out", {32'h0, got.lo}, {32'h0, want.lo});
      end
      if (got.hi !== want.hi) begin
        report_mismatch("block_high_out", {32'h0, got.hi}, {32'h0, want.hi});
      end
    end
  endtask

  // Load all four key words on consecutive cycles; only called while idle.
  task automatic write_key(input key_t key);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_WORD0;
    cfg_wdata <= key.k0;
    @(posedge clk);
    cfg_index <= REG_KEY_WORD1;
    cfg_wdata <= key.k1;
    @(posedge clk);
    cfg_index <= REG_KEY_WORD2;
    cfg_wdata <= key.k2;
    @(posedge clk);
    cfg_index <= REG_KEY_WORD3;
    cfg_wdata <= key.k3;
    @(posedge clk);
    cfg_we     <= 1'b0;
    active_key  = key;
  endtask

  // Offer one word and record its expected block once it is accepted.
  task automatic send_word(input func_t op, input logic [31:0] v0, input logic [31:0] v1,
                           input bit known, input block_t typed);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= op;
    in_ch.block_low_in  <= v0;
    in_ch.block_high_in <= v1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    last_result = tea_transform(op, v0, v1, active_key);
    last_op     = op;
    expected_blocks.push_back(known ? typed : last_result);
  endtask

  // Wait until every expected block has come back.
  task automatic drain_pipeline();
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request, then check.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      check_block('{lo: out_ch.block_low_out, hi: out_ch.block_high_out});
    end
  end

  // Main sequence: reset, directed table, then random phases under new keys.
  initial begin
    key_t phase_key;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_ENCRYPT;
    in_ch.block_low_in  <= 32'h0;
    in_ch.block_high_in <= 32'h0;
    out_ch.ready        <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_KEY_WORD0;
    cfg_wdata           <= 32'h0;
    rst_n               <= 1'b0;
    active_key           = '0;
    last_result          = '0;
    last_op              = FUNC_ENCRYPT;
    mismatch_count       = 0;
    idle_on              = 1'b1;
    hold_off_cycles      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset key.
    for (int d = 0; d < DIRECTED_COUNT; d++) begin
      send_word(directed_vectors[d].op, directed_vectors[d].v0, directed_vectors[d].v1,
                directed_vectors[d].known, directed_vectors[d].result);
    end
    in_ch.valid <= 1'b0;
    drain_pipeline();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       phase_key = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        2:       phase_key = '{32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'hffff_fffe};
        5:       phase_key = '0;
        default: phase_key = '{$urandom, $urandom, $urandom, $urandom};
      endcase
      write_key(phase_key);

      // The first phase opens with back-to-back words against a long result
      // stall, so the pipeline fills up and the input side backs off.
      if (p == 0) begin
        idle_on         = 1'b0;
        hold_off_cycles = LONG_HOLD_CYCLES;
      end

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ((n % 40 == 0) && !(p == 0 && n < 80)) begin
          idle_on = ($urandom_range(0, 3) != 0);
        end
        // A quarter of the words feed the last result back the other way.
        if ($urandom_range(0, 3) == 0) begin
          send_word((last_op == FUNC_ENCRYPT) ? FUNC_DECRYPT : FUNC_ENCRYPT,
                    last_result.lo, last_result.hi, 1'b0, '0);
        end else begin
          send_word(func_t'($urandom_range(0, 1)), random_word(), random_word(), 1'b0, '0);
        end
      end
      in_ch.valid <= 1'b0;
      idle_on      = 1'b1;
      drain_pipeline();
    end

    // Allow for any stray result before the verdict.
    repeat (RESULT_LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_blocks.size() == 0) begin
      $display("tea_block_cipher: match");
    end else begin
      $display("tea_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
